>>> sv/vide_pkg.sv
`default_nettype none

package vide_pkg;

	// Command codes
	localparam logic [2:0] CMD_TPR      = 3'd0;
	localparam logic [2:0] CMD_EOI      = 3'd1;
	localparam logic [2:0] CMD_SELF_IPI = 3'd2;
	localparam logic [2:0] CMD_ICR_LO   = 3'd3;
	localparam logic [2:0] CMD_DELIVER  = 3'd4;

	// Exit kinds
	localparam logic [2:0] EXIT_NONE     = 3'd0;
	localparam logic [2:0] EXIT_TPR_THR  = 3'd1;
	localparam logic [2:0] EXIT_VIRT_EOI = 3'd2;
	localparam logic [2:0] EXIT_APIC_WR  = 3'd3;
	localparam logic [2:0] EXIT_GP       = 3'd4;

	// APIC register offsets reported on a trapped write
	localparam logic [11:0] OFF_EOI      = 12'h0B0;
	localparam logic [11:0] OFF_ICR_LO   = 12'h300;
	localparam logic [11:0] OFF_SELF_IPI = 12'h3F0;

	// ICR low bits that must be clear for a fixed self-IPI
	localparam logic [31:0] ICR_MUST_BE_ZERO = 32'hfff3b700;
	localparam logic [1:0]  ICR_SHORT_SELF   = 2'b01;

	localparam logic [7:0] PRIO_CLASS_MASK = 8'hf0;
	localparam logic [7:0] MIN_VECTOR      = 8'd16;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_VID_EN    = 3'd0;
	localparam logic [2:0] REG_IWIN_EXIT = 3'd1;
	localparam logic [2:0] REG_TPR_THR   = 3'd2;
	localparam logic [2:0] REG_EOI_MAP0  = 3'd3;
	localparam logic [2:0] REG_EOI_MAP1  = 3'd4;
	localparam logic [2:0] REG_EOI_MAP2  = 3'd5;
	localparam logic [2:0] REG_EOI_MAP3  = 3'd6;

	localparam int MAP_WORDS = 4;

	// Status of the highest-vector search unit
	typedef struct packed {
		logic       busy;
		logic       done;
		logic [7:0] vector;
	} scan_stat_t;

endpackage

`default_nettype wire

>>> sv/vide_scan.sv
`default_nettype none

// Highest set vector of a 256-bit map, one 64-bit word per cycle from the top word down.
module vide_scan import vide_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] word,
	output logic [1:0]       word_idx,
	output scan_stat_t       stat
);

	logic       busy_q;
	logic [1:0] idx_q;
	logic [5:0] msb;
	logic       hit;

	// Priority-encode the word under inspection
	always_comb begin
		msb = '0;
		for (int i = 0; i < 64; i++) begin
			if (word[i]) begin
				msb = 6'(i);
			end
		end
	end

	assign hit         = (word != '0);
	assign word_idx    = idx_q;
	assign stat.busy   = busy_q;
	assign stat.done   = busy_q && (hit || (idx_q == 2'd0));
	assign stat.vector = hit ? {idx_q, msb} : 8'd0;

	// Step down one word per cycle until a set bit or the bottom word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= 2'(MAP_WORDS - 1);
		end else if (stat.done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			idx_q <= idx_q - 2'd1;
		end
	end

endmodule

`default_nettype wire

>>> sv/virtual_interrupt_delivery_engine_core.sv
`default_nettype none

// Virtual APIC interrupt delivery engine. Each command (TPR write, EOI, self-IPI,
// ICR-low write, deliver) is taken on the input channel while the engine is idle
// and produces exactly one result with the exit kind, the pending flag and the
// requesting, servicing and priority values after the command. A command passes
// through the EXEC and FINISH states; the result is registered as the engine
// leaves FINISH, and the input is free again at the same time. An EOI that goes
// ahead and a deliver that finds an interrupt pending also pass through SCAN,
// searching a 256-bit vector map for its highest set bit, one 64-bit word per
// cycle. The input is stalled while a command is in work; the result sits in an
// output register, so the next command may be taken while it waits, and that
// command then holds in its last cycle until the register is free. Configuration
// goes through the APB port, 64-bit registers at byte address 8*index; the user
// must write it only while idle, as the block itself does not enforce this.
module virtual_interrupt_delivery_engine_core import vide_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	// commands
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  cmd,
	input  wire logic [31:0] data,
	// results
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             pending,
	output logic [2:0]       exit_kind,
	output logic [11:0]      exit_detail,
	output logic             delivered,
	output logic [7:0]       delivered_vector,
	output logic [7:0]       request_vector,
	output logic [7:0]       service_vector,
	output logic [7:0]       processor_priority
);

	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SCAN, ST_FINISH} state_t;

	state_t      state_q;

	// configuration registers
	logic        vid_en_q;
	logic        iwin_exit_q;
	logic [3:0]  tpr_thr_q;
	logic [63:0] eoi_map_q [MAP_WORDS];

	// architectural state
	logic [63:0] req_map_q [MAP_WORDS];
	logic [63:0] svc_map_q [MAP_WORDS];
	logic [7:0]  requesting_q;
	logic [7:0]  servicing_q;
	logic [7:0]  ppr_q;
	logic [7:0]  tpr_q;
	logic        pending_q;

	// command in work
	logic [2:0]  cmd_q;
	logic [31:0] data_q;
	logic [2:0]  kind_q;
	logic [11:0] detail_q;
	logic        deliv_q;
	logic [7:0]  dvec_q;
	logic        do_ppr_q;
	logic        scan_svc_q;

	// result register
	logic        out_valid_q;
	logic        res_pending_q;
	logic [2:0]  res_kind_q;
	logic [11:0] res_detail_q;
	logic        res_deliv_q;
	logic [7:0]  res_dvec_q;
	logic [7:0]  res_req_q;
	logic [7:0]  res_svc_q;
	logic [7:0]  res_ppr_q;

	logic        cfg_wr;
	logic        in_xfer;
	logic        out_free;
	logic        out_load;
	logic        data_hi_zero;
	logic        icr_self;
	logic [7:0]  vec;
	logic        eoi_go;
	logic        dlv_go;
	logic        scan_start;
	logic [1:0]  scan_idx;
	logic [63:0] scan_word;
	scan_stat_t  scan_stat;
	logic [7:0]  ppr_next;
	logic        pending_next;
	logic        eoi_hit;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_FINISH) && out_free;

	// Decode the command in work
	assign vec          = data_q[7:0];
	assign data_hi_zero = (data_q[31:8] == 24'd0);
	assign icr_self     = ((data_q & ICR_MUST_BE_ZERO) == 32'd0)
		&& (data_q[19:18] == ICR_SHORT_SELF);
	assign eoi_go       = vid_en_q && (data_q == 32'd0);
	assign dlv_go       = pending_q;
	assign eoi_hit      = eoi_map_q[servicing_q[7:6]][servicing_q[5:0]];
	assign scan_start   = (state_q == ST_EXEC)
		&& (((cmd_q == CMD_EOI) && eoi_go) || ((cmd_q == CMD_DELIVER) && dlv_go));

	// Feed the search unit from the map being searched
	assign scan_word = scan_svc_q ? svc_map_q[scan_idx] : req_map_q[scan_idx];

	vide_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scan_start),
		.word     (scan_word),
		.word_idx (scan_idx),
		.stat     (scan_stat)
	);

	// Recompute processor priority and the pending flag at the end of a command
	always_comb begin
		ppr_next = ppr_q;
		if (do_ppr_q) begin
			if (tpr_q[7:4] >= servicing_q[7:4]) begin
				ppr_next = tpr_q;
			end else begin
				ppr_next = servicing_q & PRIO_CLASS_MASK;
			end
		end
		pending_next = !iwin_exit_q && (requesting_q[7:4] > ppr_next[7:4]);
	end

	// Register read-back
	always_comb begin
		case (paddr[5:3])
			REG_VID_EN:    prdata = {63'd0, vid_en_q};
			REG_IWIN_EXIT: prdata = {63'd0, iwin_exit_q};
			REG_TPR_THR:   prdata = {60'd0, tpr_thr_q};
			REG_EOI_MAP0:  prdata = eoi_map_q[0];
			REG_EOI_MAP1:  prdata = eoi_map_q[1];
			REG_EOI_MAP2:  prdata = eoi_map_q[2];
			REG_EOI_MAP3:  prdata = eoi_map_q[3];
			default:       prdata = 64'd0;
		endcase
	end

	// Sequencer, state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			vid_en_q      <= 1'b0;
			iwin_exit_q   <= 1'b0;
			tpr_thr_q     <= '0;
			for (int i = 0; i < MAP_WORDS; i++) begin
				eoi_map_q[i] <= '0;
				req_map_q[i] <= '0;
				svc_map_q[i] <= '0;
			end
			requesting_q  <= '0;
			servicing_q   <= '0;
			ppr_q         <= '0;
			tpr_q         <= '0;
			pending_q     <= 1'b0;
			cmd_q         <= '0;
			data_q        <= '0;
			kind_q        <= EXIT_NONE;
			detail_q      <= '0;
			deliv_q       <= 1'b0;
			dvec_q        <= '0;
			do_ppr_q      <= 1'b0;
			scan_svc_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			res_pending_q <= 1'b0;
			res_kind_q    <= EXIT_NONE;
			res_detail_q  <= '0;
			res_deliv_q   <= 1'b0;
			res_dvec_q    <= '0;
			res_req_q     <= '0;
			res_svc_q     <= '0;
			res_ppr_q     <= '0;
		end else begin
			// configuration writes
			if (cfg_wr) begin
				case (paddr[5:3])
					REG_VID_EN:    vid_en_q     <= pwdata[0];
					REG_IWIN_EXIT: iwin_exit_q  <= pwdata[0];
					REG_TPR_THR:   tpr_thr_q    <= pwdata[3:0];
					REG_EOI_MAP0:  eoi_map_q[0] <= pwdata;
					REG_EOI_MAP1:  eoi_map_q[1] <= pwdata;
					REG_EOI_MAP2:  eoi_map_q[2] <= pwdata;
					REG_EOI_MAP3:  eoi_map_q[3] <= pwdata;
					default: ;
				endcase
			end

			// drop the result once transferred, unless a new one replaces it
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						cmd_q    <= cmd;
						data_q   <= data;
						kind_q   <= EXIT_NONE;
						detail_q <= '0;
						deliv_q  <= 1'b0;
						dvec_q   <= '0;
						do_ppr_q <= 1'b0;
						state_q  <= ST_EXEC;
					end
				end

				ST_EXEC: begin
					// search a map only for EOI and a deliver that goes ahead
					state_q <= scan_start ? ST_SCAN : ST_FINISH;
					case (cmd_q)
						CMD_TPR: begin
							if (!data_hi_zero) begin
								kind_q <= EXIT_GP;
							end else begin
								tpr_q <= vec;
								if (vid_en_q) begin
									do_ppr_q <= 1'b1;
								end else if (vec[7:4] < tpr_thr_q) begin
									kind_q <= EXIT_TPR_THR;
								end
							end
						end
						CMD_EOI: begin
							if (!vid_en_q) begin
								kind_q   <= EXIT_APIC_WR;
								detail_q <= OFF_EOI;
							end else if (!eoi_go) begin
								kind_q <= EXIT_GP;
							end else begin
								svc_map_q[servicing_q[7:6]][servicing_q[5:0]] <= 1'b0;
								scan_svc_q <= 1'b1;
								do_ppr_q   <= 1'b1;
								if (eoi_hit) begin
									kind_q   <= EXIT_VIRT_EOI;
									detail_q <= {4'd0, servicing_q};
								end
							end
						end
						CMD_SELF_IPI: begin
							if (!vid_en_q) begin
								kind_q   <= EXIT_APIC_WR;
								detail_q <= OFF_SELF_IPI;
							end else if (!data_hi_zero) begin
								kind_q <= EXIT_GP;
							end else if (vec < MIN_VECTOR) begin
								kind_q   <= EXIT_APIC_WR;
								detail_q <= OFF_SELF_IPI;
							end else begin
								req_map_q[vec[7:6]][vec[5:0]] <= 1'b1;
								if (vec >= requesting_q) begin
									requesting_q <= vec;
								end
							end
						end
						CMD_ICR_LO: begin
							if (vid_en_q && icr_self && (vec >= MIN_VECTOR)) begin
								req_map_q[vec[7:6]][vec[5:0]] <= 1'b1;
								if (vec >= requesting_q) begin
									requesting_q <= vec;
								end
							end else begin
								kind_q   <= EXIT_APIC_WR;
								detail_q <= OFF_ICR_LO;
							end
						end
						CMD_DELIVER: begin
							if (dlv_go) begin
								svc_map_q[requesting_q[7:6]][requesting_q[5:0]] <= 1'b1;
								req_map_q[requesting_q[7:6]][requesting_q[5:0]] <= 1'b0;
								servicing_q <= requesting_q;
								ppr_q       <= requesting_q & PRIO_CLASS_MASK;
								deliv_q     <= 1'b1;
								dvec_q      <= requesting_q;
								scan_svc_q  <= 1'b0;
							end
						end
						default: ;
					endcase
				end

				ST_SCAN: begin
					// take the highest vector left in the searched map
					if (scan_stat.done) begin
						if (scan_svc_q) begin
							servicing_q <= scan_stat.vector;
						end else begin
							requesting_q <= scan_stat.vector;
						end
						state_q <= ST_FINISH;
					end
				end

				ST_FINISH: begin
					// hold here until the result register is free
					if (out_free) begin
						ppr_q         <= ppr_next;
						pending_q     <= pending_next;
						out_valid_q   <= 1'b1;
						res_pending_q <= pending_next;
						res_kind_q    <= kind_q;
						res_detail_q  <= detail_q;
						res_deliv_q   <= deliv_q;
						res_dvec_q    <= dvec_q;
						res_req_q     <= requesting_q;
						res_svc_q     <= servicing_q;
						res_ppr_q     <= ppr_next;
						state_q       <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign pending            = res_pending_q;
	assign exit_kind          = res_kind_q;
	assign exit_detail        = res_detail_q;
	assign delivered          = res_deliv_q;
	assign delivered_vector   = res_dvec_q;
	assign request_vector     = res_req_q;
	assign service_vector     = res_svc_q;
	assign processor_priority = res_ppr_q;

endmodule

`default_nettype wire

>>> tb/virtual_interrupt_delivery_engine_core_tb.sv
`timescale 1ns / 100ps

module virtual_interrupt_delivery_engine_core_tb import vide_pkg::*; ();

	// One exit report as the engine returns it
	typedef struct packed {
		logic        pending;
		logic [2:0]  exit_kind;
		logic [11:0] exit_detail;
		logic        delivered;
		logic [7:0]  delivered_vector;
		logic [7:0]  request_vector;
		logic [7:0]  service_vector;
		logic [7:0]  processor_priority;
	} exit_report_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_HALF, STALL_BURSTY, STALL_LIGHT} stall_pattern_t;

	// Virtual APIC shadow: tracks the vector maps and priorities, queues exit reports
	class vapic_scoreboard;
		logic         vid_en;
		logic         iwin_exit;
		logic [3:0]   tpr_thr;
		logic [255:0] eoi_exit;
		logic [255:0] req_map;
		logic [255:0] svc_map;
		logic [7:0]   req_vec;
		logic [7:0]   svc_vec;
		logic [7:0]   ppr;
		logic [7:0]   tpr;
		logic         pend;
		exit_report_t exit_reports[$];
		int unsigned  checked;
		int unsigned  mismatches;
		int unsigned  failures;

		function new();
			vid_en = 1'b0;
			iwin_exit = 1'b0;
			tpr_thr = '0;
			eoi_exit = '0;
			req_map = '0;
			svc_map = '0;
			req_vec = '0;
			svc_vec = '0;
			ppr = '0;
			tpr = '0;
			pend = 1'b0;
			checked = 0;
			mismatches = 0;
			failures = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [63:0] val);
			case (idx)
				REG_VID_EN:    vid_en = val[0];
				REG_IWIN_EXIT: iwin_exit = val[0];
				REG_TPR_THR:   tpr_thr = val[3:0];
				REG_EOI_MAP0:  eoi_exit[63:0] = val;
				REG_EOI_MAP1:  eoi_exit[127:64] = val;
				REG_EOI_MAP2:  eoi_exit[191:128] = val;
				REG_EOI_MAP3:  eoi_exit[255:192] = val;
				default: ;
			endcase
		endfunction

		function int outstanding();
			return exit_reports.size();
		endfunction

		// Highest set vector of a map, 0 when empty
		function logic [7:0] top_vector(logic [255:0] m);
			for (int i = 255; i >= 0; i--)
				if (m[i])
					return i[7:0];
			return 8'd0;
		endfunction

		function void refresh_ppr();
			if (tpr[7:4] >= svc_vec[7:4])
				ppr = tpr;
			else
				ppr = svc_vec & PRIO_CLASS_MASK;
		endfunction

		function void post_vector(logic [7:0] v);
			req_map[v] = 1'b1;
			if (v >= req_vec)
				req_vec = v;
		endfunction

		// Advance the shadow state by one command and queue its exit report
		function void take_command(logic [2:0] op, logic [31:0] arg);
			exit_report_t r;
			logic [7:0]   v;
			logic         icr_self;
			r = '0;
			case (op)
				CMD_TPR: begin
					if (arg[31:8] != 0) begin
						r.exit_kind = EXIT_GP;
					end else begin
						tpr = arg[7:0];
						if (vid_en)
							refresh_ppr();
						else if (tpr[7:4] < tpr_thr)
							r.exit_kind = EXIT_TPR_THR;
					end
				end
				CMD_EOI: begin
					if (!vid_en) begin
						r.exit_kind = EXIT_APIC_WR;
						r.exit_detail = OFF_EOI;
					end else if (arg != 0) begin
						r.exit_kind = EXIT_GP;
					end else begin
						v = svc_vec;
						svc_map[v] = 1'b0;
						svc_vec = top_vector(svc_map);
						refresh_ppr();
						if (eoi_exit[v]) begin
							r.exit_kind = EXIT_VIRT_EOI;
							r.exit_detail = {4'd0, v};
						end
					end
				end
				CMD_SELF_IPI: begin
					if (!vid_en) begin
						r.exit_kind = EXIT_APIC_WR;
						r.exit_detail = OFF_SELF_IPI;
					end else if (arg[31:8] != 0) begin
						r.exit_kind = EXIT_GP;
					end else if (arg[7:0] < MIN_VECTOR) begin
						r.exit_kind = EXIT_APIC_WR;
						r.exit_detail = OFF_SELF_IPI;
					end else begin
						post_vector(arg[7:0]);
					end
				end
				CMD_ICR_LO: begin
					v = arg[7:0];
					icr_self = ((arg & ICR_MUST_BE_ZERO) == 0) && (arg[19:18] == ICR_SHORT_SELF);
					if (vid_en && icr_self && v >= MIN_VECTOR) begin
						post_vector(v);
					end else begin
						r.exit_kind = EXIT_APIC_WR;
						r.exit_detail = OFF_ICR_LO;
					end
				end
				CMD_DELIVER: begin
					if (pend) begin
						v = req_vec;
						svc_map[v] = 1'b1;
						svc_vec = v;
						ppr = v & PRIO_CLASS_MASK;
						req_map[v] = 1'b0;
						req_vec = top_vector(req_map);
						r.delivered = 1'b1;
						r.delivered_vector = v;
					end
				end
				default: ;
			endcase
			pend = !iwin_exit && (req_vec[7:4] > ppr[7:4]);
			r.pending = pend;
			r.request_vector = req_vec;
			r.service_vector = svc_vec;
			r.processor_priority = ppr;
			exit_reports.push_back(r);
		endfunction

		function void match_exit_report(exit_report_t got);
			exit_report_t want;
			string        diff;
			if (exit_reports.size() == 0) begin
				failures++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer at %0t", $realtime);
				return;
			end
			want = exit_reports.pop_front();
			diff = "";
			if (got.pending !== want.pending) diff = {diff, " pending"};
			if (got.exit_kind !== want.exit_kind) diff = {diff, " exit_kind"};
			if (got.exit_detail !== want.exit_detail) diff = {diff, " exit_detail"};
			if (got.delivered !== want.delivered) diff = {diff, " delivered"};
			if (got.delivered_vector !== want.delivered_vector) diff = {diff, " delivered_vector"};
			if (got.request_vector !== want.request_vector) diff = {diff, " request_vector"};
			if (got.service_vector !== want.service_vector) diff = {diff, " service_vector"};
			if (got.processor_priority !== want.processor_priority)
				diff = {diff, " processor_priority"};
			if (diff != "") begin
				failures++;
				mismatches++;
				if (mismatches <= 10) begin
					$display("result %0d mismatch on%s at %0t", checked, diff, $realtime);
					$display("  expected pend=%0b kind=%0d det=%03h dlv=%0b dvec=%02h req=%02h svc=%02h ppr=%02h",
						want.pending, want.exit_kind, want.exit_detail, want.delivered,
						want.delivered_vector, want.request_vector, want.service_vector,
						want.processor_priority);
					$display("  actual   pend=%0b kind=%0d det=%03h dlv=%0b dvec=%02h req=%02h svc=%02h ppr=%02h",
						got.pending, got.exit_kind, got.exit_detail, got.delivered,
						got.delivered_vector, got.request_vector, got.service_vector,
						got.processor_priority);
				end
			end
			checked++;
		endfunction

		function void close();
			if (exit_reports.size() != 0) begin
				failures++;
				$display("%0d expected results never arrived", exit_reports.size());
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  cmd = '0;
	logic [31:0] data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        pending;
	logic [2:0]  exit_kind;
	logic [11:0] exit_detail;
	logic        delivered;
	logic [7:0]  delivered_vector;
	logic [7:0]  request_vector;
	logic [7:0]  service_vector;
	logic [7:0]  processor_priority;

	vapic_scoreboard sb;
	int              burst_left = 1;
	logic [6:0]      stall_cnt = '0;
	stall_pattern_t  stall_mode = STALL_NONE;

	virtual_interrupt_delivery_engine_core u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.prdata             (prdata),
		.pready             (pready),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.cmd                (cmd),
		.data               (data),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.pending            (pending),
		.exit_kind          (exit_kind),
		.exit_detail        (exit_detail),
		.delivered          (delivered),
		.delivered_vector   (delivered_vector),
		.request_vector     (request_vector),
		.service_vector     (service_vector),
		.processor_priority (processor_priority)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver back-pressure: pick a new pattern each time the 7-bit counter wraps
	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 7'd1;
		if (stall_cnt == 0)
			stall_mode <= stall_pattern_t'($urandom_range(0, 3));
		case (stall_mode)
			STALL_NONE:   out_stall <= 1'b0;
			STALL_HALF:   out_stall <= 1'($urandom_range(0, 1));
			STALL_BURSTY: out_stall <= (stall_cnt[2:0] != 3'd0);
			default:      out_stall <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Watch both channels; check results before noting the new command
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.match_exit_report({pending, exit_kind, exit_detail, delivered,
					delivered_vector, request_vector, service_vector, processor_priority});
			if (in_valid && !in_stall)
				sb.take_command(cmd, data);
		end
	end

	task automatic apb_write(input logic [2:0] idx, input logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic configure(input logic vid, input logic iwin, input logic [3:0] thr,
			input logic [255:0] eoi_bits);
		apb_write(REG_VID_EN, {63'd0, vid});
		apb_write(REG_IWIN_EXIT, {63'd0, iwin});
		apb_write(REG_TPR_THR, {60'd0, thr});
		apb_write(REG_EOI_MAP0, eoi_bits[63:0]);
		apb_write(REG_EOI_MAP1, eoi_bits[127:64]);
		apb_write(REG_EOI_MAP2, eoi_bits[191:128]);
		apb_write(REG_EOI_MAP3, eoi_bits[255:192]);
	endtask

	// Hold the command until the engine takes it
	task automatic send_cmd(input logic [2:0] op, input logic [31:0] arg);
		in_valid <= 1'b1;
		cmd <= op;
		data <= arg;
		do @(posedge clk); while (in_stall);
	endtask

	// Send in bursts with idle gaps between them
	task automatic send_paced(input logic [2:0] op, input logic [31:0] arg);
		send_cmd(op, arg);
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
		end
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain();
		if (in_valid)
			in_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
		repeat (2) @(posedge clk);
	endtask

	function automatic logic [255:0] random_map();
		logic [255:0] m;
		for (int i = 0; i < 8; i++)
			m[32*i +: 32] = $urandom;
		return m;
	endfunction

	// Mostly well-formed commands with random content, some noise
	task automatic send_random(output bit counted);
		int          pick;
		int          sub;
		logic [2:0]  op;
		logic [31:0] arg;
		pick = $urandom_range(0, 99);
		sub = $urandom_range(0, 9);
		counted = 1'b1;
		if (pick < 22) begin
			op = CMD_SELF_IPI;
			arg = (sub == 0) ? $urandom : (sub == 1) ? $urandom_range(0, 15) : $urandom_range(16, 255);
		end else if (pick < 38) begin
			op = CMD_ICR_LO;
			if (sub == 0) begin
				arg = $urandom;
			end else begin
				arg = $urandom & ~ICR_MUST_BE_ZERO;
				arg[19:18] = ICR_SHORT_SELF;
				arg[7:0] = (sub == 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(16, 255));
			end
		end else if (pick < 62) begin
			op = CMD_DELIVER;
			arg = $urandom;
		end else if (pick < 78) begin
			op = CMD_EOI;
			arg = (sub == 0) ? ($urandom | 32'd1) : 32'd0;
		end else if (pick < 96) begin
			op = CMD_TPR;
			arg = (sub == 0) ? $urandom : (sub < 5) ? $urandom_range(0, 95) : $urandom_range(0, 255);
		end else begin
			op = 3'($urandom_range(5, 7));
			arg = $urandom;
			counted = 1'b0;
		end
		send_paced(op, arg);
	endtask

	initial begin
		int  done;
		bit  counted;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Delivery mode off: trapped writes, TPR threshold, GP on wide TPR
		configure(1'b0, 1'b0, 4'd8, '0);
		send_cmd(CMD_TPR, 32'h0000_0035);
		send_cmd(CMD_TPR, 32'h0000_0080);
		send_cmd(CMD_TPR, 32'h0000_0100);
		send_cmd(CMD_TPR, 32'hffff_ffff);
		send_cmd(CMD_EOI, 32'd0);
		send_cmd(CMD_SELF_IPI, 32'h0000_0040);
		send_cmd(CMD_ICR_LO, 32'h0004_0041);
		send_cmd(CMD_DELIVER, 32'd0);
		send_cmd(3'd7, 32'd0);
		send_cmd(3'd5, 32'hffff_ffff);
		drain();

		// Delivery mode on: EOI on empty service map, GP cases, low vectors, delivery order
		configure(1'b1, 1'b0, 4'd15, '1);
		send_cmd(CMD_TPR, 32'd0);
		send_cmd(CMD_EOI, 32'd0);
		send_cmd(CMD_EOI, 32'd1);
		send_cmd(CMD_SELF_IPI, 32'h0000_0100);
		send_cmd(CMD_SELF_IPI, 32'h0000_000f);
		send_cmd(CMD_SELF_IPI, 32'h0000_0010);
		send_cmd(CMD_SELF_IPI, 32'h0000_00ff);
		send_cmd(CMD_ICR_LO, 32'h0004_00e0);
		send_cmd(CMD_ICR_LO, 32'h0004_0005);
		send_cmd(CMD_ICR_LO, 32'h000c_0020);
		send_cmd(CMD_ICR_LO, 32'h8004_0030);
		send_cmd(CMD_DELIVER, 32'd0);
		send_cmd(CMD_DELIVER, 32'd0);
		send_cmd(CMD_EOI, 32'd0);
		send_cmd(CMD_TPR, 32'h0000_00e5);
		send_cmd(CMD_TPR, 32'h0000_0010);
		send_cmd(CMD_DELIVER, 32'd0);
		send_cmd(3'd6, 32'h5555_aaaa);
		drain();

		// Random phases, each under its own register setting
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: configure(1'b1, 1'b0, 4'd0, random_map());
				1: configure(1'b1, 1'b0, 4'd15, '1);
				2: configure(1'b1, 1'b1, 4'd7, '0);
				3: configure(1'b0, 1'b0, 4'd15, random_map());
				4: configure(1'b1, 1'b0, 4'($urandom_range(0, 15)), random_map());
				5: configure(1'b0, 1'b1, 4'd0, '1);
				6: configure(1'b1, 1'b0, 4'($urandom_range(0, 15)), random_map());
				default: configure(1'b1, 1'b0, 4'd3, random_map());
			endcase
			done = 0;
			while (done < 228) begin
				send_random(counted);
				if (counted)
					done++;
				// hold off now and then until the engine has caught up
				if ($urandom_range(0, 99) == 0)
					drain();
			end
			drain();
		end

		repeat (10) @(posedge clk);
		sb.close();
		if (sb.failures == 0)
			$display("[virtual_interrupt_delivery_engine_core] OK");
		else
			$display("[virtual_interrupt_delivery_engine_core] ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("timeout with %0d results outstanding", sb.outstanding());
		$display("[virtual_interrupt_delivery_engine_core] ERROR");
		$finish;
	end

endmodule
